FILE: src/a85se_pkg.sv
// ============================================================================
// a85se_pkg - shared types and constants for the Ascii85 stream encoder
// Holds the item structs of both channels, the group record passed from the
// front to the back, and the arithmetic constants for base-85 conversion.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package a85se_pkg;

  // Base-85 digit arithmetic
  localparam int unsigned DIGIT_BASE  = 85;
  localparam int unsigned CHAR_OFFSET = 33;
  localparam int unsigned FULL_DIGITS = 5;
  // Divide-by-85 steps per group; the last quotient is the top digit
  localparam int unsigned NUM_DIV     = FULL_DIGITS - 1;

  // x / 85 == (x * RECIP_85) >> RECIP_SHIFT, exact for every 32-bit x
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

  // Group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       run_last;
  } out_item_t;

  // One group ready for conversion: padded word and number of digits to emit
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  ndig;
  } group_t;

endpackage

`default_nettype wire

FILE: src/a85se_front.sv
// ============================================================================
// a85se_front - byte collector
// Packs bytes big-endian into a group and posts a complete or flushed group,
// zero-padded, together with its digit count.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module a85se_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  output logic                  full,
  input  a85se_pkg::in_item_t   in_item,
  output logic                  grp_push,
  output a85se_pkg::group_t     grp,
  input  wire                   grp_full
);
  import a85se_pkg::*;

  logic [23:0] group_word;
  logic [1:0]  group_count;
  logic        accept;
  logic [31:0] word;

  assign full   = grp_full;
  assign accept = push && !grp_full;
  assign word   = {group_word, in_item.data_byte};

  always_comb begin
    grp_push = accept && ((group_count == 2'd3) || in_item.stream_end);
    grp.word = word;
    grp.ndig = 3'(FULL_DIGITS);
    if (group_count != 2'd3) begin
      // pad with zero bytes at the low end
      case (group_count)
        2'd0:    grp.word = {word[7:0], 24'd0};
        2'd1:    grp.word = {word[15:0], 16'd0};
        2'd2:    grp.word = {word[23:0], 8'd0};
        default: grp.word = word;
      endcase
      grp.ndig = {1'b0, group_count} + 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_word  <= '0;
      group_count <= '0;
    end else if (accept) begin
      if (grp_push) begin
        group_word  <= '0;
        group_count <= '0;
      end else begin
        group_word  <= word[23:0];
        group_count <= group_count + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/a85se_queue.sv
// ============================================================================
// a85se_queue - group queue
// Small first-in first-out store that decouples the collector from the
// converter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module a85se_queue #(
  parameter int unsigned DEPTH = a85se_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr_en,
  input  a85se_pkg::group_t  wr_data,
  output logic               full,
  input  wire                rd_en,
  output logic               valid,
  output a85se_pkg::group_t  rd_data
);
  import a85se_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  group_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == DEPTH_CNT);
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/a85se_back.sv
// ============================================================================
// a85se_back - base-85 converter and digit emitter
// Divides each group by 85 four times (multiply by reciprocal, then reduce),
// hands the digits to an emitter that drives the output register one digit
// per cycle while the receiver pops, as the next group converts.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module a85se_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  grp_valid,
  input  a85se_pkg::group_t    grp,
  output logic                 grp_pop,
  output logic                 empty,
  input  wire                  pop,
  output a85se_pkg::out_item_t out_item
);
  import a85se_pkg::*;

  typedef enum logic [2:0] {
    CONV_IDLE = 3'b001,
    CONV_MUL  = 3'b010,
    CONV_RED  = 3'b100
  } conv_state_t;

  conv_state_t        conv_state;
  logic [31:0]        conv_x;
  logic [2:0]         conv_n;
  logic [1:0]         conv_step;
  logic [QUOT_W-1:0]  prod_hi;
  logic [6:0]         conv_dig [2:4];

  logic [63:0]        product;
  logic [31:0]        quot;
  logic [31:0]        rem;
  logic [6:0]         rdig;
  logic               final_step;
  logic               handoff;
  logic               load;

  logic [6:0]         emit_dig [FULL_DIGITS];
  logic [2:0]         emit_n;
  logic [2:0]         emit_idx;
  logic               emit_busy;
  logic               emit_take;
  logic               emit_last;
  logic               emit_free;
  logic               out_valid;

  // Divide step: quotient from the registered product, remainder by shift-add
  assign product = {32'd0, conv_x} * {32'd0, RECIP_85};
  assign quot    = {{(32 - QUOT_W){1'b0}}, prod_hi};
  assign rem     = conv_x - (quot * 32'(DIGIT_BASE));
  assign rdig    = rem[6:0];

  assign final_step = (conv_state == CONV_RED) && (conv_step == 2'(NUM_DIV - 1));
  assign emit_take  = emit_busy && (!out_valid || pop);
  assign emit_last  = (emit_idx == emit_n - 3'd1);
  assign emit_free  = !emit_busy || (emit_take && emit_last);
  assign handoff    = final_step && emit_free;
  assign load       = grp_valid && ((conv_state == CONV_IDLE) || handoff);
  assign grp_pop    = load;
  assign empty      = !out_valid;

  // Converter
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_state <= CONV_IDLE;
      conv_step  <= '0;
    end else begin
      case (conv_state)
        CONV_IDLE: begin
          if (load) begin
            conv_state <= CONV_MUL;
            conv_step  <= '0;
          end
        end
        CONV_MUL: begin
          conv_state <= CONV_RED;
        end
        CONV_RED: begin
          if (!final_step) begin
            conv_state <= CONV_MUL;
            conv_step  <= conv_step + 2'd1;
          end else if (handoff) begin
            conv_state <= load ? CONV_MUL : CONV_IDLE;
            conv_step  <= '0;
          end
        end
        default: begin
          conv_state <= CONV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      conv_x <= grp.word;
      conv_n <= grp.ndig;
    end else if ((conv_state == CONV_RED) && !final_step) begin
      conv_dig[3'd4 - {1'b0, conv_step}] <= rdig;
      conv_x <= quot;
    end
    if (conv_state == CONV_MUL) begin
      prod_hi <= product[63:RECIP_SHIFT];
    end
  end

  // Emitter: most significant digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (handoff) begin
        emit_busy <= 1'b1;
        emit_idx  <= '0;
      end else if (emit_take) begin
        emit_idx <= emit_idx + 3'd1;
        if (emit_last) begin
          emit_busy <= 1'b0;
        end
      end
      if (emit_take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      emit_dig[0] <= quot[6:0];
      emit_dig[1] <= rdig;
      emit_dig[2] <= conv_dig[2];
      emit_dig[3] <= conv_dig[3];
      emit_dig[4] <= conv_dig[4];
      emit_n      <= conv_n;
    end
    if (emit_take) begin
      out_item.digit_char <= emit_dig[emit_idx] + 7'(CHAR_OFFSET);
      out_item.run_last   <= emit_last;
    end
  end

endmodule

`default_nettype wire

FILE: src/ascii85_stream_encoder_top.sv
// ============================================================================
// ascii85_stream_encoder_top - Ascii85 stream encoder
// Encodes a byte stream into base-85 characters, no 'z' shortcut, no
// delimiters; a flag on the input byte ends the stream and flushes a group.
// ----------------------------------------------------------------------------
// Input side: drive in_item and raise push; the item is taken on a clock
//   edge where push is high and full is low. stream_end marks the last byte.
// Output side: while empty is low, out_item holds the oldest character;
//   raise pop to take it. run_last flags the last character of one group.
// Path: the group closed by a byte goes through the group queue, the
//   converter and the emitter into the output register, where empty falls;
//   the group's characters follow one per cycle while pop stays high.
// Conversion: four divides by 85 per group, each a 32x32 reciprocal
//   multiply and a reduce; a short flushed group costs as much as a full
//   one. Emission overlaps conversion of the next group.
// Reset (rst, synchronous) drops any partial group and any queued or
//   pending characters.
// A stalled receiver holds the output register; the emitter, the converter
//   and the group queue then fill in turn and full rises.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ascii85_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = a85se_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  a85se_pkg::in_item_t  in_item,
  output logic                 empty,
  input  wire                  pop,
  output a85se_pkg::out_item_t out_item
);
  import a85se_pkg::*;

  // Front to queue
  logic   grp_push;
  group_t grp_in;
  logic   grp_full;
  // Queue to back
  logic   grp_valid;
  logic   grp_pop;
  group_t grp_out;

  // Collect bytes into groups; hold push off when the group queue is full
  a85se_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .grp_push (grp_push),
    .grp      (grp_in),
    .grp_full (grp_full)
  );

  // Decouple collection from conversion
  a85se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_push),
    .wr_data (grp_in),
    .full    (grp_full),
    .rd_en   (grp_pop),
    .valid   (grp_valid),
    .rd_data (grp_out)
  );

  // Convert each group and stream its characters out
  a85se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp_out),
    .grp_pop   (grp_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: verif/a85_digit_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// a85_digit_checker - scoreboard for the Ascii85 stream encoder
// Watches both queue sides, predicts the characters that each accepted byte
// produces, and compares every popped character against the oldest one.
// ============================================================================
module a85_digit_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  a85se_pkg::in_item_t  in_item,
  input  logic                 empty,
  input  logic                 pop,
  input  a85se_pkg::out_item_t out_item,
  output int unsigned          mismatch_count,
  output int unsigned          chars_pending
);
  import a85se_pkg::*;

  out_item_t   expected_chars[$];
  logic [23:0] held_bytes = '0;
  logic [1:0]  held_count = '0;

  // Split word into five base-85 digits and queue the first ndig of them.
  task automatic queue_chars(input logic [31:0] word, input int unsigned ndig);
    logic [6:0]  digit [5];
    logic [31:0] rest;
    out_item_t   ch;
    rest = word;
    for (int i = 4; i >= 0; i--) begin
      digit[i] = 7'((rest % DIGIT_BASE) + CHAR_OFFSET);
      rest     = rest / DIGIT_BASE;
    end
    for (int unsigned i = 0; i < ndig; i++) begin
      ch.digit_char = digit[i];
      ch.run_last   = (i == ndig - 1);
      expected_chars.push_back(ch);
    end
  endtask

  task automatic encode_byte(input in_item_t item);
    logic [31:0] word;
    word = {held_bytes, item.data_byte};
    if (held_count == 2'd3) begin
      queue_chars(word, FULL_DIGITS);
    end else if (item.stream_end) begin
      // pad the short group with zero bytes at the low end
      queue_chars(word << (8 * (3 - int'(held_count))), int'(held_count) + 2);
    end else begin
      held_bytes = word[23:0];
      held_count = held_count + 2'd1;
      return;
    end
    held_bytes = '0;
    held_count = '0;
  endtask

  always @(posedge clk) begin : check_chars
    out_item_t want;
    if (rst) begin
      expected_chars.delete();
      held_bytes     = '0;
      held_count     = '0;
      mismatch_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected item: digit_char %0d run_last %0b",
                 out_item.digit_char, out_item.run_last);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_item.digit_char !== want.digit_char) begin
            $error("digit_char expected %0d actual %0d", want.digit_char,
                   out_item.digit_char);
            mismatch_count++;
          end
          if (out_item.run_last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last,
                   out_item.run_last);
            mismatch_count++;
          end
        end
      end
      if (push && !full) begin
        encode_byte(in_item);
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

FILE: verif/ascii85_stream_encoder_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// ascii85_stream_encoder_top_tb - testbench for the Ascii85 stream encoder
// Feeds directed groups (all-zero, all-ones, every short flush length, full
// groups with and without a stream end) and then random byte streams under
// four sender/receiver idling phases; the checker scores every character.
// ============================================================================
module ascii85_stream_encoder_top_tb;
  import a85se_pkg::*;

  // Random bytes per idling phase; four phases plus the directed items
  // give roughly 430 bytes in all.
  localparam int unsigned BYTES_PER_PHASE = 101;
  // Cycles to keep watching once nothing is expected
  localparam int unsigned DRAIN_CYCLES    = 40;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic        pop     = 1'b0;
  in_item_t    in_item = '0;
  logic        full;
  logic        empty;
  out_item_t   out_item;
  int unsigned mismatch_count;
  int unsigned chars_pending;

  // Idling odds in percent, changed per phase by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned bytes_in_phase;

  always #5 clk = ~clk;

  ascii85_stream_encoder_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  a85_digit_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  // Receiver: draw a fresh pop every cycle; a stall is just pop held low.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Offer one byte, after a random number of idle cycles, and hold it
  // until the encoder takes it. push stays high into the next byte when
  // no idle cycle falls in between.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{data_byte: data, stream_end: last};
    do @(posedge clk); while (full);
    bytes_in_phase++;
  endtask

  // Lean on the all-zero and all-ones bytes, otherwise any value.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One stream of len bytes; an open stream leaves its partial group
  // pending so that the next stream continues it.
  task automatic send_stream(input int unsigned len, input logic closed);
    for (int unsigned i = 1; i <= len; i++) begin
      send_byte(pick_byte(), closed && (i == len));
    end
  endtask

  task automatic wait_drained();
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling.
    // Single-byte flushes at both extremes: two characters each.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Two- and three-byte flushes.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    // Zero group ending the stream: five '!' and no padding characters.
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // Largest group, then a mixed one, both without a stream end.
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    // A fresh group flushed after its first byte.
    send_byte(8'hAA, 1'b1);
    // Drop push and hold off until every character is back.
    push <= 1'b0;
    @(posedge clk);
    wait_drained();

    // Random streams under each idling phase; drain between phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 82;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 82;
        end
        default: begin
          send_idle_pct = 13;
          pop_stall_pct = 13;
        end
      endcase
      bytes_in_phase = 0;
      while (bytes_in_phase < BYTES_PER_PHASE) begin
        // Mostly closed streams of 1..12 bytes, some left open.
        send_stream($urandom_range(1, 12), $urandom_range(5) != 0);
      end
      push <= 1'b0;
      @(posedge clk);
      wait_drained();
    end

    // Watch a while longer for stray characters.
    pop_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/a85se_pkg.sv
src/a85se_front.sv
src/a85se_queue.sv
src/a85se_back.sv
src/ascii85_stream_encoder_top.sv
verif/a85_digit_checker.sv
verif/ascii85_stream_encoder_top_tb.sv
